>>> hdl/rpb_pkg.sv
// Shared constants and types of the raster to page bitmap converter.
package rpb_pkg;

  localparam int IMAGE_WIDTH  = 128;
  localparam int IMAGE_HEIGHT = 32;

  localparam int ROW_BYTES   = IMAGE_WIDTH / 8;
  localparam int BYTE_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int ROW_W       = $clog2(IMAGE_HEIGHT);
  localparam int BAND_ROWS   = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One emitting input byte, with the stored rows of its band.
  typedef struct packed {
    logic [BAND_ROWS-1:0][7:0] held;
    logic [7:0]                pix;
    logic [2:0]                band_row;
    logic [1:0]                page;
    logic [3:0]                col_hi;
    logic                      frame_last;
  } job_t;

endpackage

>>> hdl/rpb_ram.sv
// Generic single-port RAM with registered read.
module rpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hdl/rpb_front.sv
// Front end: position counters, band store, and job build for emitting bytes.
module rpb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        pixel_byte,
  output logic              full,
  output logic              q_push,
  output rpb_pkg::job_t     q_job,
  input  logic              q_full
);

  logic [rpb_pkg::BYTE_W-1:0] byte_pos;
  logic [rpb_pkg::ROW_W-1:0]  row_pos;
  logic                       s1_valid;
  logic                       s1_valid_next;
  logic [7:0]                 s1_pix;
  logic [2:0]                 s1_band_row;
  logic [1:0]                 s1_page;
  logic [3:0]                 s1_col_hi;
  logic                       s1_frame_last;

  logic                       accept;
  logic [2:0]                 band_row;
  logic                       last_row;
  logic                       last_byte;
  logic                       emit;
  logic [rpb_pkg::BAND_ROWS-1:0][7:0] held;

  assign full      = s1_valid && q_full;
  assign accept    = push && !full;
  assign band_row  = row_pos[2:0];
  assign last_row  = (row_pos == rpb_pkg::ROW_W'(rpb_pkg::IMAGE_HEIGHT - 1));
  assign last_byte = (byte_pos == rpb_pkg::BYTE_W'(rpb_pkg::ROW_BYTES - 1));
  assign emit      = (band_row == 3'd7) || last_row;

  // One RAM lane per stored row of the band.
  for (genvar k = 0; k < rpb_pkg::BAND_ROWS; k++) begin : g_lane
    rpb_ram #(
      .WIDTH(8),
      .DEPTH(rpb_pkg::ROW_BYTES)
    ) u_lane (
      .clk  (clk),
      .we   (accept && !emit && (band_row == 3'(k))),
      .re   (accept && emit),
      .addr (byte_pos),
      .wdata(pixel_byte),
      .rdata(held[k])
    );
  end

  assign s1_valid_next = (accept && emit) || (s1_valid && q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= '0;
      row_pos  <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
      if (accept) begin
        if (last_byte) begin
          byte_pos <= '0;
          row_pos  <= last_row ? '0 : row_pos + 1'b1;
        end else begin
          byte_pos <= byte_pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_pix        <= pixel_byte;
      s1_band_row   <= band_row;
      s1_page       <= 2'(row_pos >> 3);
      s1_col_hi     <= 4'(byte_pos);
      s1_frame_last <= last_row && last_byte;
    end
  end

  assign q_push           = s1_valid && !q_full;
  assign q_job.held       = held;
  assign q_job.pix        = s1_pix;
  assign q_job.band_row   = s1_band_row;
  assign q_job.page       = s1_page;
  assign q_job.col_hi     = s1_col_hi;
  assign q_job.frame_last = s1_frame_last;

endmodule

>>> hdl/rpb_queue.sv
// Short job queue between front and back ends.
module rpb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  rpb_pkg::job_t wdata,
  output logic          full,
  input  logic          rd,
  output rpb_pkg::job_t rdata,
  output logic          empty
);

  rpb_pkg::job_t               entries [rpb_pkg::QUEUE_DEPTH];
  logic [rpb_pkg::QPTR_W-1:0]  wr_ptr;
  logic [rpb_pkg::QPTR_W-1:0]  rd_ptr;
  logic [rpb_pkg::QCNT_W-1:0]  count;
  logic                        do_wr;
  logic                        do_rd;

  assign full  = (count == rpb_pkg::QCNT_W'(rpb_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == rpb_pkg::QPTR_W'(rpb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == rpb_pkg::QPTR_W'(rpb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

>>> hdl/rpb_back.sv
// Back end: transposes a job to 8 column bytes, one per cycle on pop.
module rpb_back (
  input  logic          clk,
  input  logic          rst,
  input  rpb_pkg::job_t q_job,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    page_byte,
  output logic [1:0]    page_index,
  output logic [6:0]    column_index,
  output logic          last_of_run,
  output logic          end_of_frame
);

  rpb_pkg::job_t job;
  logic          job_valid;
  logic [2:0]    col;
  logic          out_valid;

  logic          out_ok;
  logic          emit_now;
  logic          job_done;
  logic [7:0]    col_byte;

  assign out_ok   = !out_valid || pop;
  assign emit_now = job_valid && out_ok;
  assign job_done = emit_now && (col == 3'd7);
  assign q_pop    = !q_empty && (!job_valid || job_done);
  assign empty    = !out_valid;

  always_comb begin
    col_byte = '0;
    for (int k = 0; k < rpb_pkg::BAND_ROWS; k++) begin
      if (3'(k) < job.band_row) begin
        col_byte[k] = job.held[k][col];
      end
    end
    col_byte[job.band_row] = job.pix[col];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        job_valid <= 1'b1;
        col       <= '0;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end else if (emit_now) begin
        col <= col + 1'b1;
      end
      if (out_ok) begin
        out_valid <= job_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
    if (emit_now) begin
      page_byte    <= col_byte;
      page_index   <= job.page;
      column_index <= {job.col_hi, col};
      last_of_run  <= (col == 3'd7);
      end_of_frame <= (col == 3'd7) && job.frame_last;
    end
  end

endmodule

>>> hdl/raster_to_page_bitmap_converter.sv
// Top level of the raster to page bitmap converter.
// Takes a 1-bit-per-pixel image one byte per push in row-major order and
// produces page/column bytes for a monochrome display. A byte of a band's
// first seven rows is written into the band store (seven RAM lanes, no
// clearing needed). A byte of a band's eighth row, or of the frame's last
// row, reads the band store and yields eight result bytes, one per cycle
// while pop is held, through the single result register. A two-entry job
// queue lets storing bytes be taken while results of earlier bytes are
// still being drained.
module raster_to_page_bitmap_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] pixel_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] page_byte,
  output logic [1:0] page_index,
  output logic [6:0] column_index,
  output logic       last_of_run,
  output logic       end_of_frame
);

  rpb_pkg::job_t fq_job;
  rpb_pkg::job_t qb_job;
  logic          fq_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;

  rpb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pixel_byte(pixel_byte),
    .full      (full),
    .q_push    (fq_push),
    .q_job     (fq_job),
    .q_full    (q_full)
  );

  rpb_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (fq_push),
    .wdata(fq_job),
    .full (q_full),
    .rd   (q_pop),
    .rdata(qb_job),
    .empty(q_empty)
  );

  rpb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_job       (qb_job),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .page_byte   (page_byte),
    .page_index  (page_index),
    .column_index(column_index),
    .last_of_run (last_of_run),
    .end_of_frame(end_of_frame)
  );

endmodule

>>> hdl/rpb_checker.sv
// Port-level assertions for the raster to page bitmap converter.
module rpb_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] page_byte,
  input logic [1:0] page_index,
  input logic [6:0] column_index,
  input logic       last_of_run,
  input logic       end_of_frame
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_of_run) |=>
      (!empty && column_index == 7'($past(column_index) + 7'd1)
       && page_index == $past(page_index)))
    else $error("run of eight column bytes broken");

  a_last_col: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last_of_run == (column_index[2:0] == 3'd7)))
    else $error("last_of_run not on eighth column");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_frame) |-> last_of_run)
    else $error("end_of_frame without last_of_run");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(page_byte) && $stable(column_index)))
    else $error("stalled item changed");

endmodule

bind raster_to_page_bitmap_converter rpb_checker u_rpb_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .page_byte   (page_byte),
  .page_index  (page_index),
  .column_index(column_index),
  .last_of_run (last_of_run),
  .end_of_frame(end_of_frame)
);
